[hdl/leb_pkg.sv]
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and constants for the Lorenz Euler byte generator: register
// layout, fixed-point constants and the multiplier request/response structs.
// ----------------------------------------------------------------------------
package leb_pkg;

  // datapath widths
  localparam int WORD_W     = 64;
  localparam int PROD_W     = 128;
  localparam int PART_W     = 32;
  localparam int RHO_W      = 46;
  localparam int START_W    = 44;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // register reset values (28.0 and 1.0 with 40 fraction bits)
  localparam logic [RHO_W-1:0]   RHO_RESET   = 46'd30786325577728;
  localparam logic [START_W-1:0] START_RESET = 44'd1099511627776;

  // beta = 8/3 in Q2.61, truncated
  localparam logic signed [WORD_W-1:0] BETA_Q61   = 64'sd6148914691236517205;
  localparam int                       BETA_SHIFT = 61;
  // half step 0.0005 in Q0.64, rounded to nearest
  localparam logic signed [WORD_W-1:0] HALF_DT_Q64 = 64'sd9223372036854776;
  // output scale applied to the fractional part of |x|
  localparam logic [32:0]              SCALE       = 33'd1000000;

  // register indexes
  typedef enum logic [1:0] {
    REG_RHO,
    REG_START_X,
    REG_START_Y,
    REG_START_Z
  } reg_idx_t;

  // configuration register contents
  typedef struct packed {
    logic [RHO_W-1:0]   rho;
    logic [START_W-1:0] start_x;
    logic [START_W-1:0] start_y;
    logic [START_W-1:0] start_z;
  } cfg_regs_t;

  // shared multiplier request and response
  typedef struct packed {
    logic                     start;
    logic signed [WORD_W-1:0] a;
    logic signed [WORD_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } mul_rsp_t;

endpackage

[hdl/leb_in_if.sv]
// ----------------------------------------------------------------------------
// leb_in_if
// Request channel into the generator: restart and emit flags.
// ----------------------------------------------------------------------------
interface leb_in_if;
  logic valid;
  logic ready;
  logic restart;
  logic emit;

  modport source (output valid, output restart, output emit, input ready);
  modport sink   (input valid, input restart, input emit, output ready);
endinterface

[hdl/leb_out_if.sv]
// ----------------------------------------------------------------------------
// leb_out_if
// Result channel out of the generator: one byte per emitting request.
// ----------------------------------------------------------------------------
interface leb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

[hdl/leb_cfg_regs.sv]
// ----------------------------------------------------------------------------
// leb_cfg_regs
// APB-style register file holding rho and the three start values.
// Registers sit at 8-byte strides; pready is always high.
// ----------------------------------------------------------------------------
module leb_cfg_regs import leb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_regs_t             regs
);

  cfg_regs_t regs_r;
  cfg_regs_t regs_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign regs   = regs_r;

  // write decode
  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      unique case (idx)
        REG_RHO:     regs_nxt.rho     = pwdata[RHO_W-1:0];
        REG_START_X: regs_nxt.start_x = pwdata[START_W-1:0];
        REG_START_Y: regs_nxt.start_y = pwdata[START_W-1:0];
        REG_START_Z: regs_nxt.start_z = pwdata[START_W-1:0];
        default:     regs_nxt = regs_r;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_RHO:     prdata = CFG_DATA_W'(regs_r.rho);
      REG_START_X: prdata = CFG_DATA_W'(regs_r.start_x);
      REG_START_Y: prdata = CFG_DATA_W'(regs_r.start_y);
      REG_START_Z: prdata = CFG_DATA_W'(regs_r.start_z);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.rho     <= RHO_RESET;
      regs_r.start_x <= START_RESET;
      regs_r.start_y <= START_RESET;
      regs_r.start_z <= START_RESET;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

[hdl/leb_mul.sv]
// ----------------------------------------------------------------------------
// leb_mul
// Shared 64x64 signed multiplier built from four 33x33 partial products,
// one per cycle, accumulated into a 128-bit register. Done pulses once the
// last partial has been added; the product then holds until the next start.
// ----------------------------------------------------------------------------
module leb_mul import leb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam int P_W = 2 * (PART_W + 1);

  logic signed [WORD_W-1:0] a_r;
  logic signed [WORD_W-1:0] b_r;
  logic [1:0]               cnt_r;
  logic                     run_r;
  logic                     pv_r;
  logic                     plast_r;
  logic                     done_r;
  logic [1:0]               psh_r;
  logic signed [P_W-1:0]    p_r;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PART_W:0]   a_part;
  logic signed [PART_W:0]   b_part;

  // operand halves: low halves unsigned, high halves signed
  always_comb begin
    a_part = cnt_r[0] ? $signed({a_r[WORD_W-1], a_r[WORD_W-1:PART_W]})
                      : $signed({1'b0, a_r[PART_W-1:0]});
    b_part = cnt_r[1] ? $signed({b_r[WORD_W-1], b_r[WORD_W-1:PART_W]})
                      : $signed({1'b0, b_r[PART_W-1:0]});
  end

  assign rsp.done = done_r;
  assign rsp.prod = acc_r;

  // sequencing of the four partial products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      plast_r <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      pv_r    <= run_r;
      plast_r <= run_r && (cnt_r == 2'd3);
      done_r  <= pv_r && plast_r;
      if (req.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) run_r <= 1'b0;
      end
    end
  end

  // partial product and accumulate
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (run_r) begin
      p_r   <= a_part * b_part;
      psh_r <= {1'b0, cnt_r[0]} + {1'b0, cnt_r[1]};
    end
    if (req.start) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + (PROD_W'(p_r) <<< (PART_W * int'(psh_r)));
    end
  end

endmodule

[hdl/lorenz_euler_byte_generator.sv]
// ----------------------------------------------------------------------------
// lorenz_euler_byte_generator
// Lorenz system in signed fixed point, one explicit Euler step per request,
// with an optional byte taken from the fractional part of |x|.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+------------------------------
//   in_ch    | in  | valid / ready    | restart, emit
//   out_ch   | out | valid / ready    | out_byte
//   apb      | in  | psel, penable    | paddr, pwdata, prdata (64 bit)
//
// A request runs three setup states (load, prep, fx), then six products (seven
// when emit is set) through the shared multiplier, each one four partial
// products, accumulate and hand-off.
// Synchronous active-low reset loads the start values and the register resets.
// A result waits in the output register; a following emitting request stalls
// in its last state only while that register is still full.
// ----------------------------------------------------------------------------
module lorenz_euler_byte_generator import leb_pkg::*; #(
  parameter int FRAC_BITS = 40
) (
  input  logic                  clk,
  input  logic                  rst_n,
  leb_in_if.sink                in_ch,
  leb_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SW    = FRAC_BITS + 8;
  localparam int PXY_W = 2 * SW - FRAC_BITS;

  localparam logic [WORD_W-1:0]        ST_MAX_U = (64'd1 << (SW - 1)) - 64'd1;
  localparam logic signed [WORD_W:0]   ST_MAX   = $signed({1'b0, ST_MAX_U});
  localparam logic signed [WORD_W:0]   ST_MIN   = -ST_MAX - 65'sd1;
  localparam logic signed [WORD_W-1:0] W_MAX    = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] W_MIN    = {1'b1, {(WORD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_PREP,
    S_FX,
    S_MSTART,
    S_MWAIT,
    S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_XD,
    OP_XY,
    OP_ZB,
    OP_HX,
    OP_HY,
    OP_HZ,
    OP_OUT
  } op_t;

  // saturate a wide value to signed 64 bits
  function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [PROD_W-1:0] w);
    if (w[PROD_W-1:WORD_W-1] == {(PROD_W-WORD_W+1){w[WORD_W-1]}}) begin
      return w[WORD_W-1:0];
    end else if (w[PROD_W-1]) begin
      return W_MIN;
    end else begin
      return W_MAX;
    end
  endfunction

  // clamp a sum to the state range
  function automatic logic signed [SW-1:0] sat_state(input logic signed [WORD_W:0] s);
    if (s > ST_MAX) begin
      return ST_MAX[SW-1:0];
    end else if (s < ST_MIN) begin
      return ST_MIN[SW-1:0];
    end else begin
      return s[SW-1:0];
    end
  endfunction

  // start value, pinned to the largest state value when too wide
  function automatic logic signed [SW-1:0] load_start(input logic [START_W-1:0] v);
    if (WORD_W'(v) > ST_MAX_U) begin
      return ST_MAX_U[SW-1:0];
    end else begin
      return SW'(v);
    end
  endfunction

  cfg_regs_t regs;
  mul_req_t  mreq;
  mul_rsp_t  mrsp;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   restart_r, restart_nxt;
  logic   emit_r, emit_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;

  logic signed [SW-1:0] pos_x_r, pos_x_nxt;
  logic signed [SW-1:0] pos_y_r, pos_y_nxt;
  logic signed [SW-1:0] pos_z_r, pos_z_nxt;

  logic signed [WORD_W-1:0] dyx_r, dyx_nxt;
  logic signed [WORD_W-1:0] drz_r, drz_nxt;
  logic signed [WORD_W-1:0] fx_r, fx_nxt;
  logic signed [WORD_W-1:0] fy_r, fy_nxt;
  logic signed [WORD_W-1:0] fz_r, fz_nxt;
  logic signed [PXY_W-1:0]  pxy_r, pxy_nxt;

  logic signed [SW-1:0]     x_mag;
  logic [FRAC_BITS-1:0]     x_frac;
  logic signed [WORD_W-1:0] delta;

  leb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs    (regs)
  );

  leb_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  assign in_ch.ready     = (state_r == S_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;

  // fractional part of |x| for the output byte
  assign x_mag  = pos_x_r[SW-1] ? -pos_x_r : pos_x_r;
  assign x_frac = x_mag[FRAC_BITS-1:0];
  assign delta  = mrsp.prod[PROD_W-1:WORD_W];

  // multiplier operand select
  always_comb begin
    mreq.start = (state_r == S_MSTART);
    case (op_r)
      OP_XD:   begin mreq.a = WORD_W'(pos_x_r);  mreq.b = drz_r;            end
      OP_XY:   begin mreq.a = WORD_W'(pos_x_r);  mreq.b = WORD_W'(pos_y_r); end
      OP_ZB:   begin mreq.a = WORD_W'(pos_z_r);  mreq.b = BETA_Q61;         end
      OP_HX:   begin mreq.a = fx_r;              mreq.b = HALF_DT_Q64;      end
      OP_HY:   begin mreq.a = fy_r;              mreq.b = HALF_DT_Q64;      end
      OP_HZ:   begin mreq.a = fz_r;              mreq.b = HALF_DT_Q64;      end
      OP_OUT:  begin mreq.a = WORD_W'(x_frac);   mreq.b = WORD_W'(SCALE);   end
      default: begin mreq.a = '0;                mreq.b = '0;               end
    endcase
  end

  // step sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    restart_nxt   = restart_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    pos_z_nxt     = pos_z_r;
    dyx_nxt       = dyx_r;
    drz_nxt       = drz_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    fz_nxt        = fz_r;
    pxy_nxt       = pxy_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          restart_nxt = in_ch.restart;
          emit_nxt    = in_ch.emit;
          state_nxt   = S_LOAD;
        end
      end
      // optional reload from the start registers
      S_LOAD: begin
        if (restart_r) begin
          pos_x_nxt = load_start(regs.start_x);
          pos_y_nxt = load_start(regs.start_y);
          pos_z_nxt = load_start(regs.start_z);
        end
        state_nxt = S_PREP;
      end
      // differences y - x and rho - z
      S_PREP: begin
        dyx_nxt   = sat_word(PROD_W'(pos_y_r) - PROD_W'(pos_x_r));
        drz_nxt   = sat_word($signed(PROD_W'(regs.rho)) - PROD_W'(pos_z_r));
        state_nxt = S_FX;
      end
      // fx = 10 * (y - x)
      S_FX: begin
        fx_nxt    = sat_word((PROD_W'(dyx_r) <<< 3) + (PROD_W'(dyx_r) <<< 1));
        op_nxt    = OP_XD;
        state_nxt = S_MSTART;
      end
      S_MSTART: begin
        state_nxt = S_MWAIT;
      end
      // consume a finished product
      S_MWAIT: begin
        if (mrsp.done) begin
          state_nxt = S_MSTART;
          case (op_r)
            OP_XD: begin
              fy_nxt = sat_word((mrsp.prod >>> FRAC_BITS) - PROD_W'(pos_y_r));
              op_nxt = OP_XY;
            end
            OP_XY: begin
              pxy_nxt = PXY_W'(mrsp.prod >>> FRAC_BITS);
              op_nxt  = OP_ZB;
            end
            OP_ZB: begin
              fz_nxt = sat_word(PROD_W'(pxy_r) - (mrsp.prod >>> BETA_SHIFT));
              op_nxt = OP_HX;
            end
            OP_HX: begin
              pos_x_nxt = sat_state((WORD_W+1)'(pos_x_r) + (WORD_W+1)'(delta));
              op_nxt    = OP_HY;
            end
            OP_HY: begin
              pos_y_nxt = sat_state((WORD_W+1)'(pos_y_r) + (WORD_W+1)'(delta));
              op_nxt    = OP_HZ;
            end
            OP_HZ: begin
              pos_z_nxt = sat_state((WORD_W+1)'(pos_z_r) + (WORD_W+1)'(delta));
              op_nxt    = OP_OUT;
              state_nxt = emit_r ? S_MSTART : S_IDLE;
            end
            OP_OUT: begin
              state_nxt = S_EMIT;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      // post the byte once the output register is free
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = mrsp.prod[FRAC_BITS+7:FRAC_BITS];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state, lorenz state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_XD;
      restart_r   <= 1'b0;
      emit_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_byte_r  <= '0;
      pos_x_r     <= load_start(START_RESET);
      pos_y_r     <= load_start(START_RESET);
      pos_z_r     <= load_start(START_RESET);
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      restart_r   <= restart_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
      out_byte_r  <= out_byte_nxt;
      pos_x_r     <= pos_x_nxt;
      pos_y_r     <= pos_y_nxt;
      pos_z_r     <= pos_z_nxt;
    end
  end

  // derivative working registers
  always_ff @(posedge clk) begin
    dyx_r <= dyx_nxt;
    drz_r <= drz_nxt;
    fx_r  <= fx_nxt;
    fy_r  <= fy_nxt;
    fz_r  <= fz_nxt;
    pxy_r <= pxy_nxt;
  end

endmodule

[hdl/leb_checker.sv]
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks for the Lorenz byte generator, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte
);

  // a request keeps the block busy through its load and prep states
  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input ready returned too early after a request");

  // a result is posted only as the block returns to idle
  a_post_at_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result posted while the block was still busy");

  // reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its byte
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("output byte changed while stalled");

endmodule

bind lorenz_euler_byte_generator leb_checker u_leb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives step requests into the Lorenz Euler byte generator and compares every
// emitted byte with a fixed-point Lorenz model kept in the bench. Registers go
// through their range ends, a negative-x run, a full-scale run and random
// settings, under three sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench import leb_pkg::*;;

  localparam int FRAC    = 40;
  localparam int STATE_W = FRAC + 8;

  localparam logic [CFG_DATA_W-1:0] RHO_LOW    = 64'd30786325577728;
  localparam logic [CFG_DATA_W-1:0] RHO_HIGH   = 64'd43980465111040;
  localparam logic [CFG_DATA_W-1:0] START_LOW  = 64'd1099511627776;
  localparam logic [CFG_DATA_W-1:0] START_HIGH = 64'd10995116277760;

  typedef logic signed [STATE_W-1:0] state_t;
  typedef logic signed [WORD_W-1:0]  word_t;
  typedef logic signed [PROD_W-1:0]  wide_t;

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;

  leb_in_if  in_ch ();
  leb_out_if out_ch ();

  // bench copy of the registers and the Lorenz state
  logic [RHO_W-1:0]   model_rho;
  logic [START_W-1:0] model_start_x, model_start_y, model_start_z;
  state_t             pos_x, pos_y, pos_z;

  logic [7:0] expected_bytes[$];
  int         error_count = 0;
  int         in_idle_pct = 31;
  int         out_idle_pct = 77;

  lorenz_euler_byte_generator #(.FRAC_BITS(FRAC)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // overall time limit
  initial begin
    #30000000;
    $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // fixed-point Lorenz model
  // ---------------------------------------------------------------------------

  // clamp to signed 64 bits
  function automatic word_t sat_word(input wide_t w);
    if (w[PROD_W-1:WORD_W-1] == {(PROD_W-WORD_W+1){w[PROD_W-1]}}) return w[WORD_W-1:0];
    return w[PROD_W-1] ? {1'b1, {(WORD_W-1){1'b0}}} : {1'b0, {(WORD_W-1){1'b1}}};
  endfunction

  // clamp to the state range
  function automatic state_t sat_state(input wide_t w);
    word_t v;
    v = sat_word(w);
    if (v[WORD_W-1:STATE_W-1] == {(WORD_W-STATE_W+1){v[WORD_W-1]}}) return v[STATE_W-1:0];
    return v[WORD_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
  endfunction

  // start values above the state range load as its top
  function automatic state_t load_start(input logic [START_W-1:0] r);
    wide_t top, v;
    top = 1;
    top = (top <<< (STATE_W - 1)) - 1;
    v = r;
    if (v > top) return top[STATE_W-1:0];
    return v[STATE_W-1:0];
  endfunction

  // floor(f * h) with h = dt/2
  function automatic word_t euler_delta(input word_t f);
    wide_t a, b, p;
    a = f;
    b = HALF_DT_Q64;
    p = a * b;
    return p[PROD_W-1:WORD_W];
  endfunction

  function automatic void advance_lorenz(input bit restart, output logic [7:0] byte_val);
    wide_t a, b, p, q;
    word_t d, fx, fy, fz;
    state_t x, y, z;
    logic [STATE_W-1:0] mag;
    logic [PROD_W-1:0] scaled, frac, scale_w;
    if (restart) begin
      pos_x = load_start(model_start_x);
      pos_y = load_start(model_start_y);
      pos_z = load_start(model_start_z);
    end
    x = pos_x;
    y = pos_y;
    z = pos_z;
    // dx = sigma (y - x)
    a = y;
    b = x;
    d = sat_word(a - b);
    a = d;
    fx = sat_word(a * 10);
    // dy = x (rho - z) - y
    a = model_rho;
    b = z;
    d = sat_word(a - b);
    a = x;
    b = d;
    p = (a * b) >>> FRAC;
    b = y;
    fy = sat_word(p - b);
    // dz = x y - beta z
    a = x;
    b = y;
    p = (a * b) >>> FRAC;
    a = z;
    b = BETA_Q61;
    q = (a * b) >>> BETA_SHIFT;
    fz = sat_word(p - q);
    // all derivatives come from the old state
    a = x;
    pos_x = sat_state(a + euler_delta(fx));
    a = y;
    pos_y = sat_state(a + euler_delta(fy));
    a = z;
    pos_z = sat_state(a + euler_delta(fz));
    // byte from the fraction of |x|
    mag = pos_x;
    if (pos_x < 0) mag = -pos_x;
    frac = mag[FRAC-1:0];
    scale_w = SCALE;
    scaled = (frac * scale_w) >> FRAC;
    byte_val = scaled[7:0];
  endfunction

  // ---------------------------------------------------------------------------
  // shared bench tasks
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $time);
    error_count++;
  endtask

  task automatic send_request(input bit restart, input bit emit);
    logic [7:0] byte_val;
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.restart <= restart;
    in_ch.emit    <= emit;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    advance_lorenz(restart, byte_val);
    if (emit) expected_bytes = {expected_bytes, byte_val};
  endtask

  // stop sending and let the block go idle
  task automatic wait_for_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    logic [CFG_DATA_W-1:0] stored;
    stored = (idx == REG_RHO) ? CFG_DATA_W'(value[RHO_W-1:0]) : CFG_DATA_W'(value[START_W-1:0]);
    // write: setup then access
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_RHO:     model_rho     = value[RHO_W-1:0];
      REG_START_X: model_start_x = value[START_W-1:0];
      REG_START_Y: model_start_y = value[START_W-1:0];
      REG_START_Z: model_start_z = value[START_W-1:0];
      default: ;
    endcase
    // read it back
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== stored) report_mismatch("register read back", prdata, stored);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [63:0] pick_setting(input logic [63:0] lo, input logic [63:0] hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return lo + ({$urandom, $urandom} % (hi - lo + 1));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result side: random stalls and byte checks
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_bytes.size() == 0)
        report_mismatch("out_byte with no request pending", out_ch.out_byte, 0);
      else if (out_ch.out_byte !== expected_bytes[0])
        report_mismatch("out_byte", out_ch.out_byte, expected_bytes.pop_front());
      else
        void'(expected_bytes.pop_front());
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset state first, then every restart/emit pairing
  task automatic test_flag_combinations();
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b1);
    send_request(1'b1, 1'b0);
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b0);
    send_request(1'b1, 1'b1);
    send_request(1'b0, 1'b1);
  endtask

  // rho acts on the next step, start values only after a restart
  task automatic test_register_timing();
    wait_for_results();
    write_register(REG_RHO, RHO_HIGH);
    write_register(REG_START_X, START_HIGH);
    write_register(REG_START_Y, START_HIGH);
    write_register(REG_START_Z, START_HIGH);
    send_request(1'b0, 1'b1);
    send_request(1'b0, 1'b1);
    send_request(1'b1, 1'b1);
    send_request(1'b0, 1'b1);
    wait_for_results();
    write_register(REG_RHO, RHO_LOW);
    write_register(REG_START_X, START_LOW);
    write_register(REG_START_Y, START_LOW);
    write_register(REG_START_Z, START_LOW);
    send_request(1'b0, 1'b1);
    send_request(1'b1, 1'b1);
  endtask

  // rho of zero with a large z pulls y and then x below zero
  task automatic test_negative_x();
    int steps;
    wait_for_results();
    write_register(REG_RHO, '0);
    write_register(REG_START_X, START_LOW);
    write_register(REG_START_Y, START_LOW);
    write_register(REG_START_Z, {START_W{1'b1}});
    send_request(1'b1, 1'b1);
    steps = 0;
    while (pos_x >= 0 && steps < 2000) begin
      send_request(1'b0, $urandom_range(3) == 0);
      steps++;
    end
    repeat (30) send_request(1'b0, 1'b1);
  endtask

  // full-scale registers push the state toward its limits
  task automatic test_state_limits();
    wait_for_results();
    write_register(REG_RHO, {RHO_W{1'b1}});
    write_register(REG_START_X, {START_W{1'b1}});
    write_register(REG_START_Y, {START_W{1'b1}});
    write_register(REG_START_Z, {START_W{1'b1}});
    send_request(1'b1, 1'b1);
    repeat (200) send_request(1'b0, $urandom_range(1) == 1);
  endtask

  // random settings and requests under one idle mix, with a full drain midway
  task automatic test_random_traffic(input int count, input int in_pct, input int out_pct);
    wait_for_results();
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    // upper pwdata bits beyond each register are junk
    write_register(REG_RHO, pick_setting(RHO_LOW, RHO_HIGH) | ({$urandom, $urandom} << RHO_W));
    write_register(REG_START_X,
                   pick_setting(START_LOW, START_HIGH) | ({$urandom, $urandom} << START_W));
    write_register(REG_START_Y,
                   pick_setting(START_LOW, START_HIGH) | ({$urandom, $urandom} << START_W));
    write_register(REG_START_Z,
                   pick_setting(START_LOW, START_HIGH) | ({$urandom, $urandom} << START_W));
    send_request(1'b1, $urandom_range(1) == 1);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_for_results();
      send_request($urandom_range(15) == 0, $urandom_range(3) != 0);
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.restart = 1'b0;
    in_ch.emit    = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    model_rho     = RHO_RESET;
    model_start_x = START_RESET;
    model_start_y = START_RESET;
    model_start_z = START_RESET;
    pos_x         = load_start(model_start_x);
    pos_y         = load_start(model_start_y);
    pos_z         = load_start(model_start_z);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_flag_combinations();
    test_register_timing();
    test_negative_x();
    test_state_limits();
    test_random_traffic(60, 31, 77);
    test_random_traffic(60, 77, 31);
    test_random_traffic(60, 0, 0);
    wait_for_results();

    if (error_count == 0 && expected_bytes.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

[lorenz_euler_byte_generator.f]
hdl/leb_pkg.sv
hdl/leb_in_if.sv
hdl/leb_out_if.sv
hdl/leb_cfg_regs.sv
hdl/leb_mul.sv
hdl/lorenz_euler_byte_generator.sv
hdl/leb_checker.sv
sim/testbench.sv
